[hdl/brf_pkg.sv]
// Types and constants for the banked register file core.
// Holds the beat structs, action and error codes, and the mirrored-address test.
// No dependencies.
package brf_pkg;

    // Action codes
    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_WRITE  = 2'd1;
    localparam logic [1:0] ACT_LINEAR = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ADDR = 2'd1;
    localparam logic [1:0] ERR_LOOP = 2'd2;
    localparam logic [1:0] ERR_PTR  = 2'd3;

    // Special register addresses
    localparam logic [6:0] ADDR_INDF   = 7'h00;
    localparam logic [6:0] ADDR_PCL    = 7'h02;
    localparam logic [6:0] ADDR_STATUS = 7'h03;
    localparam logic [6:0] ADDR_FSR    = 7'h04;
    localparam logic [6:0] ADDR_PCLATH = 7'h0A;
    localparam logic [6:0] ADDR_INTCON = 7'h0B;

    typedef struct packed {
        logic [1:0] action;
        logic       bank;
        logic [7:0] address;
        logic [7:0] write_data;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] error_code;
        logic       changed;
        logic [6:0] changed_address;
        logic [7:0] old_value;
    } t_out_beat;

    // True for registers that are shared by both banks
    function automatic logic is_mirrored(input logic [6:0] a);
        is_mirrored = (a == ADDR_INDF) || (a == ADDR_PCL) || (a == ADDR_STATUS) ||
                      (a == ADDR_FSR) || (a == ADDR_PCLATH) || (a == ADDR_INTCON);
    endfunction

endpackage

[hdl/banked_register_file_indirect_core.sv]
// Two-bank byte register file with an indirect register at address 0.
// Holds the access decode, both bank memories and the result register.
// Depends on brf_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one access per beat:
//   a banked read, a banked write or a linear read over both banks. Address 0
//   is the indirect register; it resolves through the pointer byte at address 4.
//   Output channel (o_out_valid / i_out_stall / o_out) returns one result beat
//   per access: read data, error code, and for writes the target and old byte.
// Timing:
//   An access is accepted in the idle state, which issues the memory read; the
//   execute state then modifies, writes back and loads the result register.
//   No new access is accepted while an access is in the execute state.
//   The pointer byte is shadowed in a register, so indirection needs no extra
//   memory read.
// Stall:
//   A result waits in the output register while i_out_stall is high; a new
//   access may be accepted meanwhile and holds in its execute cycle (rereading
//   its entry) until the output register frees up.
// Reset:
//   Synchronous, active low. Per-entry valid bits clear at once, so every byte
//   reads as zero after reset; no clearing pass is needed.
module banked_register_file_indirect_core
    import brf_pkg::*;
#(
    parameter int BANK_DEPTH = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    localparam int         AW       = $clog2(BANK_DEPTH);
    localparam logic [8:0] DEPTH_9  = 9'(BANK_DEPTH);
    localparam logic [8:0] LIN_TOP  = 9'(2 * BANK_DEPTH);
    localparam logic [0:0] ST_IDLE  = 1'b0;
    localparam logic [0:0] ST_EXEC  = 1'b1;

    logic [0:0]      r_state;
    logic [7:0]      r_ptr;
    logic [1:0]      r_op;
    logic [1:0]      r_err;
    logic            r_bank;
    logic [AW-1:0]   r_tgt;
    logic [7:0]      r_wdata;
    logic            r_out_valid;
    t_out_beat       r_out;

    logic [1:0]      n_err;
    logic            n_bank;
    logic [AW-1:0]   n_tgt;
    t_out_beat       n_out;
    logic [8:0]      lin_off;

    logic            in_fire;
    logic            exec_go;
    logic            wr_ok;
    logic            mirr;
    logic            we0;
    logic            we1;
    logic [AW-1:0]   rd_idx;
    logic [7:0]      rd_byte;

    logic [7:0]          mem0 [BANK_DEPTH];
    logic [7:0]          mem1 [BANK_DEPTH];
    logic [BANK_DEPTH-1:0] r_vld0;
    logic [BANK_DEPTH-1:0] r_vld1;
    logic [7:0]          r_rd0;
    logic [7:0]          r_rd1;
    logic                r_rv0;
    logic                r_rv1;

    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state == ST_EXEC);
    assign exec_go     = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign lin_off     = {1'b0, i_in.address} - DEPTH_9;

    // Decode the incoming beat: resolve indirection and range checks
    always_comb begin
        n_err  = ERR_OK;
        n_bank = i_in.bank;
        n_tgt  = i_in.address[AW-1:0];
        case (i_in.action)
            ACT_READ, ACT_WRITE: begin
                if ({1'b0, i_in.address} >= DEPTH_9) begin
                    n_err = ERR_ADDR;
                end else if (i_in.address == 8'd0) begin
                    if (r_ptr == 8'd0) begin
                        n_err = ERR_LOOP;
                    end else if ({1'b0, r_ptr} >= DEPTH_9) begin
                        n_err = ERR_PTR;
                    end else begin
                        n_tgt = r_ptr[AW-1:0];
                    end
                end
            end
            ACT_LINEAR: begin
                if ({1'b0, i_in.address} >= LIN_TOP) begin
                    n_err = ERR_ADDR;
                end else if ({1'b0, i_in.address} >= DEPTH_9) begin
                    n_bank = 1'b1;
                    n_tgt  = lin_off[AW-1:0];
                end else begin
                    n_bank = 1'b0;
                end
            end
            default: begin
                n_err = ERR_OK;
            end
        endcase
    end

    // Read the decoded entry at accept; reread the held entry while waiting
    assign rd_idx = (r_state == ST_EXEC) ? r_tgt : n_tgt;

    // Write-back controls
    assign wr_ok = exec_go && (r_op == ACT_WRITE) && (r_err == ERR_OK);
    assign mirr  = is_mirrored(7'(r_tgt));
    assign we0   = wr_ok && (!r_bank || mirr);
    assign we1   = wr_ok && (r_bank || mirr);

    // Bank memories with registered read
    always_ff @(posedge i_clk) begin
        if (we0) begin
            mem0[r_tgt] <= r_wdata;
        end
        if (we1) begin
            mem1[r_tgt] <= r_wdata;
        end
        r_rd0 <= mem0[rd_idx];
        r_rd1 <= mem1[rd_idx];
    end

    // Per-entry valid bits: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= '0;
            r_vld1 <= '0;
            r_rv0  <= 1'b0;
            r_rv1  <= 1'b0;
        end else begin
            if (we0) begin
                r_vld0[r_tgt] <= 1'b1;
            end
            if (we1) begin
                r_vld1[r_tgt] <= 1'b1;
            end
            r_rv0 <= r_vld0[rd_idx];
            r_rv1 <= r_vld1[rd_idx];
        end
    end

    assign rd_byte = r_bank ? (r_rv1 ? r_rd1 : 8'd0) : (r_rv0 ? r_rd0 : 8'd0);

    // Sequencer, pointer shadow and accepted-beat fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ptr   <= 8'd0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (exec_go) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (wr_ok && (7'(r_tgt) == ADDR_FSR)) begin
                r_ptr <= r_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= i_in.action;
            r_err   <= n_err;
            r_bank  <= n_bank;
            r_tgt   <= n_tgt;
            r_wdata <= i_in.write_data;
        end
    end

    // Result register: load on execute, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Build the result beat of the access in execute
    always_comb begin
        n_out = '0;
        n_out.error_code = r_err;
        if (r_err == ERR_OK) begin
            case (r_op)
                ACT_READ, ACT_LINEAR: begin
                    n_out.read_data = rd_byte;
                end
                ACT_WRITE: begin
                    n_out.changed         = 1'b1;
                    n_out.changed_address = 7'(r_tgt);
                    n_out.old_value       = rd_byte;
                end
                default: begin
                    n_out.read_data = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_out <= n_out;
        end
    end

    // Checks
    a_accept_enters_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_EXEC))
        else $error("accepted beat did not enter execute");

    a_ptr_follows_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_ok && (7'(r_tgt) == ADDR_FSR)) |=> (r_ptr == $past(r_wdata)))
        else $error("pointer shadow missed a write to address 4");

    a_err_zeroes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.error_code != ERR_OK)) |->
        (o_out.read_data == 8'd0 && !o_out.changed && o_out.old_value == 8'd0))
        else $error("error result carries data");

    a_write_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we0 || we1) |-> (r_err == ERR_OK && r_op == ACT_WRITE && exec_go))
        else $error("memory written without a successful write");

endmodule

[tb/banked_register_file_indirect_checker.sv]
// Scoreboard for the banked register file core: keeps an image of both banks,
// predicts one result beat per accepted access and compares the returned beats.
// Depends on brf_pkg for the beat structs and the action, error and address codes.
module banked_register_file_indirect_checker
    import brf_pkg::*;
#(
    parameter int BANK_DEPTH = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copies of both banks and the results still owed by the block
    logic [7:0] bank_zero_img [BANK_DEPTH];
    logic [7:0] bank_one_img  [BANK_DEPTH];
    t_out_beat  owed_results [$];

    // Print one line per mismatch and count every one
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    // Perform one access on the bank images and return the result it yields
    function automatic t_out_beat access_result(input t_in_beat a);
        t_out_beat  r;
        logic [7:0] ptr;
        logic [6:0] tgt;
        logic       shared;
        r = '0;
        tgt = a.address[6:0];
        ptr = a.bank ? bank_one_img[ADDR_FSR] : bank_zero_img[ADDR_FSR];
        if (a.action == ACT_READ || a.action == ACT_WRITE) begin
            if (a.address >= BANK_DEPTH) begin
                r.error_code = ERR_ADDR;
            end else if (tgt == ADDR_INDF && ptr == 8'd0) begin
                r.error_code = ERR_LOOP;
            end else if (tgt == ADDR_INDF && ptr >= BANK_DEPTH) begin
                r.error_code = ERR_PTR;
            end else begin
                // Follow the pointer for the indirect register
                if (tgt == ADDR_INDF) begin
                    tgt = ptr[6:0];
                end
                if (a.action == ACT_READ) begin
                    r.read_data = a.bank ? bank_one_img[tgt] : bank_zero_img[tgt];
                end else begin
                    r.old_value = a.bank ? bank_one_img[tgt] : bank_zero_img[tgt];
                    r.changed = 1'b1;
                    r.changed_address = tgt;
                    // Shared registers land in both banks
                    shared = tgt inside {ADDR_INDF, ADDR_PCL, ADDR_STATUS, ADDR_FSR,
                                         ADDR_PCLATH, ADDR_INTCON};
                    if (shared || !a.bank) begin
                        bank_zero_img[tgt] = a.write_data;
                    end
                    if (shared || a.bank) begin
                        bank_one_img[tgt] = a.write_data;
                    end
                end
            end
        end else if (a.action == ACT_LINEAR) begin
            if (a.address >= 2 * BANK_DEPTH) begin
                r.error_code = ERR_ADDR;
            end else if (a.address < BANK_DEPTH) begin
                r.read_data = bank_zero_img[a.address];
            end else begin
                r.read_data = bank_one_img[a.address - BANK_DEPTH];
            end
        end
        return r;
    endfunction

    // Compare each result beat with the oldest owed one, then predict new accesses
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            foreach (bank_zero_img[k]) begin
                bank_zero_img[k] = '0;
                bank_one_img[k] = '0;
            end
            owed_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result beat with nothing owed", int'(i_out), 0);
                end else begin
                    want = owed_results.pop_front();
                    if (i_out.read_data != want.read_data) begin
                        report_mismatch("read_data", int'(i_out.read_data),
                                        int'(want.read_data));
                    end
                    if (i_out.error_code != want.error_code) begin
                        report_mismatch("error_code", int'(i_out.error_code),
                                        int'(want.error_code));
                    end
                    if (i_out.changed != want.changed) begin
                        report_mismatch("changed", int'(i_out.changed), int'(want.changed));
                    end
                    if (i_out.changed_address != want.changed_address) begin
                        report_mismatch("changed_address", int'(i_out.changed_address),
                                        int'(want.changed_address));
                    end
                    if (i_out.old_value != want.old_value) begin
                        report_mismatch("old_value", int'(i_out.old_value),
                                        int'(want.old_value));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                owed_results.push_back(access_result(i_in));
            end
        end
        o_pending <= owed_results.size();
    end

endmodule

[tb/banked_register_file_indirect_core_test.sv]
// Top of the banked register file testbench: clock, reset, access stimulus and verdict.
// Depends on brf_pkg, the banked_register_file_indirect_core block and the
// banked_register_file_indirect_checker scoreboard.
module banked_register_file_indirect_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    localparam int         BANK_DEPTH       = 128;
    localparam int         RANDOM_PER_PHASE = 430;
    localparam int         HOLD_CYCLES      = 300;
    localparam int         DRAIN_CYCLES     = 8;
    localparam int         RUN_LIMIT        = 300000;
    localparam int         IN_BITS          = $bits(t_in_beat);
    localparam logic [1:0] ACT_UNUSED       = 2'd3;
    localparam logic [7:0] INDF_BYTE        = {1'b0, ADDR_INDF};
    localparam logic [7:0] FSR_BYTE         = {1'b0, ADDR_FSR};

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_beat;
    int        fail_count;
    int        pending;
    int        sender_idle_pct;
    int        receiver_idle_pct;
    int        phase_idx;
    int        cycle_count;

    banked_register_file_indirect_core #(
        .BANK_DEPTH(BANK_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_beat)
    );

    banked_register_file_indirect_checker #(
        .BANK_DEPTH(BANK_DEPTH)
    ) scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_beat),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Free-running clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drive the result stall: random holds, plus one long hold-off in the last phase
    initial begin
        int hold_left;
        bit held_once;
        hold_left = 0;
        held_once = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (phase_idx == 2 && !held_once) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = ($urandom_range(99) < receiver_idle_pct);
            end
        end
    end

    function automatic t_in_beat make_access(input logic [1:0] act, input logic bk,
                                             input logic [7:0] addr, input logic [7:0] data);
        t_in_beat b;
        b.action = act;
        b.bank = bk;
        b.address = addr;
        b.write_data = data;
        return b;
    endfunction

    // Mostly in-bank accesses around the pointer and shared registers
    function automatic t_in_beat random_access();
        t_in_beat b;
        int       pick;
        b.bank = 1'($urandom_range(1));
        b.write_data = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 3) begin
            b.action = ACT_UNUSED;
        end else if (pick < 18) begin
            b.action = ACT_LINEAR;
        end else if (pick < 60) begin
            b.action = ACT_WRITE;
        end else begin
            b.action = ACT_READ;
        end
        pick = $urandom_range(99);
        if (b.action == ACT_LINEAR) begin
            if (pick < 50) begin
                b.address = {1'($urandom_range(1)), 7'($urandom_range(0, 24))};
            end else begin
                b.address = 8'($urandom);
            end
        end else if (pick < 8) begin
            b.address = 8'($urandom);
        end else if (pick < 28) begin
            b.address = INDF_BYTE;
        end else if (pick < 43) begin
            b.address = FSR_BYTE;
        end else if (pick < 53) begin
            case ($urandom_range(3))
                0: b.address = {1'b0, ADDR_PCL};
                1: b.address = {1'b0, ADDR_STATUS};
                2: b.address = {1'b0, ADDR_PCLATH};
                default: b.address = {1'b0, ADDR_INTCON};
            endcase
        end else if (pick < 80) begin
            b.address = 8'($urandom_range(1, 24));
        end else begin
            b.address = 8'($urandom_range(1, BANK_DEPTH - 1));
        end
        // Load the pointer with zero, past-bank or useful values
        if (b.action == ACT_WRITE && b.address == FSR_BYTE) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                b.write_data = 8'h00;
            end else if (pick < 25) begin
                b.write_data = 8'($urandom_range(BANK_DEPTH, 255));
            end else if (pick < 75) begin
                b.write_data = 8'($urandom_range(1, 24));
            end else begin
                b.write_data = 8'($urandom_range(1, BANK_DEPTH - 1));
            end
        end
        return b;
    endfunction

    // Offer one beat after a random gap and hold it until accepted; call at a falling edge
    task automatic send_access(input t_in_beat beat);
        bit took;
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid = 1'b0;
            in_beat = IN_BITS'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_beat = beat;
        took = 1'b0;
        while (!took) begin
            @(posedge clk);
            took = !in_stall;
            @(negedge clk);
        end
    endtask

    // Reset, directed accesses, three random phases, drain and verdict
    initial begin
        in_valid = 1'b0;
        in_beat = '0;
        rst_n = 1'b0;
        phase_idx = 0;
        sender_idle_pct = 12;
        receiver_idle_pct = 84;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fresh banks, pointer zero, range errors
        send_access(make_access(ACT_READ, 1'b0, 8'd5, 8'h00));
        send_access(make_access(ACT_LINEAR, 1'b0, 8'hFF, 8'h00));
        send_access(make_access(ACT_READ, 1'b0, INDF_BYTE, 8'h00));
        send_access(make_access(ACT_WRITE, 1'b1, INDF_BYTE, 8'hFF));
        send_access(make_access(ACT_READ, 1'b0, 8'h80, 8'h00));
        send_access(make_access(ACT_WRITE, 1'b1, 8'hFF, 8'hFF));
        // Pointer past the bank, shared into bank 1
        send_access(make_access(ACT_WRITE, 1'b0, FSR_BYTE, 8'h80));
        send_access(make_access(ACT_READ, 1'b1, INDF_BYTE, 8'h00));
        send_access(make_access(ACT_WRITE, 1'b1, INDF_BYTE, 8'h11));
        send_access(make_access(ACT_WRITE, 1'b1, FSR_BYTE, 8'hFF));
        // Indirect write to the last entry, read back every way
        send_access(make_access(ACT_WRITE, 1'b0, FSR_BYTE, 8'h7F));
        send_access(make_access(ACT_WRITE, 1'b0, INDF_BYTE, 8'hFF));
        send_access(make_access(ACT_READ, 1'b0, 8'h7F, 8'h00));
        send_access(make_access(ACT_LINEAR, 1'b0, 8'h7F, 8'h00));
        send_access(make_access(ACT_LINEAR, 1'b1, 8'hFF, 8'h00));
        // Indirect write onto a shared register
        send_access(make_access(ACT_WRITE, 1'b1, FSR_BYTE, {1'b0, ADDR_PCLATH}));
        send_access(make_access(ACT_WRITE, 1'b1, INDF_BYTE, 8'h5A));
        send_access(make_access(ACT_LINEAR, 1'b0, 8'h8A, 8'h00));
        // Private write stays in its bank
        send_access(make_access(ACT_WRITE, 1'b1, 8'h01, 8'hA5));
        send_access(make_access(ACT_LINEAR, 1'b0, 8'h01, 8'h00));
        send_access(make_access(ACT_LINEAR, 1'b0, 8'h81, 8'h00));
        // Unused action, the STATUS and INTCON shared registers, linear view of the indirect slot
        send_access(make_access(ACT_UNUSED, 1'b1, 8'hFF, 8'hFF));
        send_access(make_access(ACT_WRITE, 1'b0, {1'b0, ADDR_STATUS}, 8'h00));
        send_access(make_access(ACT_WRITE, 1'b1, {1'b0, ADDR_INTCON}, 8'hBB));
        send_access(make_access(ACT_LINEAR, 1'b1, 8'h00, 8'h00));

        // Random phases: slow receiver, then slow sender, then full rate
        for (int p = 0; p < 3; p++) begin
            phase_idx = p;
            sender_idle_pct = (p == 0) ? 12 : (p == 1) ? 84 : 0;
            receiver_idle_pct = (p == 0) ? 84 : (p == 1) ? 12 : 0;
            repeat (RANDOM_PER_PHASE) send_access(random_access());
        end
        in_valid = 1'b0;

        // Drain owed results, then watch for stray result beats
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
